[rtl/efcr_pkg.sv]
// Shared types and constants for the encoder frame check and speed capture block.
// No dependencies; imported by every module of the block.
package efcr_pkg;

   localparam int POS_BITS   = 14;
   localparam int ANGLE_BITS = 9;
   localparam int RPM_BITS   = 24;
   localparam int RSP_DATA_BITS = 48;

   localparam logic [RPM_BITS-1:0] RPM_MAX       = 24'hFFFFFF;
   localparam logic [15:0]         MS_PER_MINUTE = 16'd60000;

   // parity coverage over the 14 data bits
   localparam logic [POS_BITS-1:0] ODD_MASK  = 14'h2AAA;
   localparam logic [POS_BITS-1:0] EVEN_MASK = 14'h1555;

   localparam logic [8:0] DEG_PER_TURN = 9'd360;

   localparam int QUEUE_DEPTH = 2;

   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_FRAME = 1'b1;

   localparam logic [1:0] CSR_RESOLUTION = 2'd0;
   localparam logic [1:0] CSR_WIN_LOW    = 2'd1;
   localparam logic [1:0] CSR_WIN_HIGH   = 2'd2;
   localparam logic [1:0] CSR_ARM        = 2'd3;

   localparam logic [13:0] WIN_LOW_RESET  = 14'd14000;
   localparam logic [14:0] WIN_HIGH_RESET = 15'd16000;
   localparam logic [14:0] ARM_RESET      = 15'd1000;

   // classified item as it travels from front to back
   typedef struct packed {
      logic                  op;
      logic                  bad;
      logic [POS_BITS-1:0]   pos;
      logic [ANGLE_BITS-1:0] angle;
   } entry_type;

   typedef struct packed {
      logic [13:0] window_low;
      logic [14:0] window_high;
      logic [14:0] arm_threshold;
   } window_cfg_type;

   typedef struct packed {
      logic [POS_BITS-1:0]   pos;
      logic                  bad;
      logic [ANGLE_BITS-1:0] angle;
      logic [RPM_BITS-1:0]   rpm;
      logic                  updated;
   } result_type;

endpackage

[rtl/encoder_frame_check_rpm.sv]
// Top level: configuration registers, front end, queue and speed back end.
// Depends on efcr_pkg, efcr_front, efcr_queue, efcr_back.
//
//   group  direction  handshake              payload
//   req_   in         req_tvalid/req_tready  tdata frame_word, tuser op
//   rsp_   out        rsp_tvalid/rsp_tready  tdata position/angle/rpm, tuser flags
//   csr_   in         csr_valid/csr_ready    csr_index, csr_data
//
// A tick or a frame without speed capture is handled in the idle state alone.
// A capture frame with elapsed time is loaded into the restoring divider, which
// yields one quotient bit per cycle; the result is written once the output is free.
// Synchronous reset clears counters, arming, speed and the queue; no clearing pass.
// Two queue entries let the front keep accepting while the back divides or
// while a result waits on rsp_tready; ticks drain past a waiting result.
module encoder_frame_check_rpm #(
   parameter int TIME_BITS     = 32,
   parameter int RPM_FRAC_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] frame_word
   input  logic        req_tuser,   // [0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [efcr_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
                                    // [13:0] position, [22:14] angle_deg,
                                    // [46:23] rpm_q8, [47] zero
   output logic [1:0]  rsp_tuser,   // [0] position_bad, [1] rpm_updated
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import efcr_pkg::*;

   logic           resolution_ff;
   window_cfg_type cfg_ff;
   entry_type      front_entry;
   entry_type      q_head;
   logic           q_full;
   logic           q_not_empty;
   logic           q_pop;
   logic           push;
   result_type     result;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         resolution_ff        <= 1'b0;
         cfg_ff.window_low    <= WIN_LOW_RESET;
         cfg_ff.window_high   <= WIN_HIGH_RESET;
         cfg_ff.arm_threshold <= ARM_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_RESOLUTION: resolution_ff        <= csr_data[0];
            CSR_WIN_LOW:    cfg_ff.window_low    <= csr_data[13:0];
            CSR_WIN_HIGH:   cfg_ff.window_high   <= csr_data[14:0];
            CSR_ARM:        cfg_ff.arm_threshold <= csr_data[14:0];
            default: ;
         endcase
      end
   end

   assign req_tready = !q_full && !reset;
   assign push       = req_tvalid && req_tready;

   efcr_front u_front (
      .resolution_mode (resolution_ff),
      .op              (req_tuser),
      .frame_word      (req_tdata),
      .entry           (front_entry)
   );

   efcr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (front_entry),
      .full       (q_full),
      .pop        (q_pop),
      .not_empty  (q_not_empty),
      .head       (q_head)
   );

   efcr_back #(
      .TIME_BITS     (TIME_BITS),
      .RPM_FRAC_BITS (RPM_FRAC_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp         (result)
   );

   assign rsp_tdata = {1'b0, result.rpm, result.angle, result.pos};
   assign rsp_tuser = {result.updated, result.bad};

endmodule

[rtl/efcr_front.sv]
// Front end: parity check, position scaling and angle of one incoming item.
// Depends on efcr_pkg.
module efcr_front (
   input  logic                 resolution_mode,
   input  logic                 op,
   input  logic [15:0]          frame_word,
   output efcr_pkg::entry_type  entry
);
   import efcr_pkg::*;

   logic                  par_odd;
   logic                  par_even;
   logic                  bad;
   logic [POS_BITS-1:0]   pos;
   logic [22:0]           deg_prod;

   assign par_odd  = ~(^(frame_word[POS_BITS-1:0] & ODD_MASK));
   assign par_even = ~(^(frame_word[POS_BITS-1:0] & EVEN_MASK));
   assign bad      = (frame_word[15] != par_odd) || (frame_word[14] != par_even);

   always_comb begin
      pos = '0;
      if (!bad) begin
         pos = resolution_mode ? {2'b00, frame_word[POS_BITS-1:2]} : frame_word[POS_BITS-1:0];
      end
   end

   // full turn is 2^14 counts in both modes
   assign deg_prod = 23'(pos) * 23'(DEG_PER_TURN);

   assign entry.op    = op;
   assign entry.bad   = bad;
   assign entry.pos   = pos;
   assign entry.angle = deg_prod[22:14];

endmodule

[rtl/efcr_queue.sv]
// Short FIFO between the classifying front end and the speed back end.
// Depends on efcr_pkg.
module efcr_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  efcr_pkg::entry_type  push_entry,
   output logic                 full,
   input  logic                 pop,
   output logic                 not_empty,
   output efcr_pkg::entry_type  head
);
   import efcr_pkg::*;

   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   entry_type           mem_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS:0]   count_ff, count_in;

   assign full      = (count_ff == (PTR_BITS+1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[rtl/efcr_back.sv]
// Back end: millisecond counter, arming, speed capture with a restoring
// divider (one quotient bit a cycle) and the result register. Depends on efcr_pkg.
module efcr_back #(
   parameter int TIME_BITS     = 32,
   parameter int RPM_FRAC_BITS = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  efcr_pkg::window_cfg_type cfg,
   input  logic                     q_not_empty,
   input  efcr_pkg::entry_type      q_head,
   output logic                     q_pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output efcr_pkg::result_type     rsp
);
   import efcr_pkg::*;

   localparam int DW       = 16 + RPM_FRAC_BITS;
   localparam int CNT_BITS = $clog2(DW);
   localparam int EW       = (DW > RPM_BITS) ? DW : RPM_BITS;
   localparam logic [DW-1:0] DIVIDEND = DW'(MS_PER_MINUTE) << RPM_FRAC_BITS;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DIVIDE = 3'b010,
      ST_DONE   = 3'b100
   } state_type;

   state_type            state_ff, state_in;
   logic [TIME_BITS-1:0] ms_count_ff, ms_count_in;
   logic [TIME_BITS-1:0] last_ms_ff, last_ms_in;
   logic                 armed_ff, armed_in;
   logic [RPM_BITS-1:0]  rpm_ff, rpm_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   result_type           rsp_ff, rsp_in;

   logic [TIME_BITS-1:0] divisor_ff, divisor_in;
   logic [TIME_BITS-1:0] rem_ff, rem_in;
   logic [DW-1:0]        quo_ff, quo_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [POS_BITS-1:0]  hold_pos_ff, hold_pos_in;
   logic [ANGLE_BITS-1:0] hold_angle_ff, hold_angle_in;

   logic                 out_free;
   logic                 capture;
   logic [TIME_BITS-1:0] elapsed;
   logic [TIME_BITS:0]   trial;
   logic [TIME_BITS:0]   trial_diff;
   logic                 trial_ok;
   logic [EW-1:0]        quo_ext;
   logic [RPM_BITS-1:0]  quo_sat;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign capture  = !q_head.bad && (q_head.pos > cfg.window_low)
                     && ({1'b0, q_head.pos} < cfg.window_high) && armed_ff;
   assign elapsed  = ms_count_ff - last_ms_ff;

   assign trial      = {rem_ff, quo_ff[DW-1]};
   assign trial_diff = trial - {1'b0, divisor_ff};
   assign trial_ok   = (trial >= {1'b0, divisor_ff});

   assign quo_ext = EW'(quo_ff);
   assign quo_sat = (quo_ext > EW'(RPM_MAX)) ? RPM_MAX : quo_ext[RPM_BITS-1:0];

   // ticks drain even while a result waits; frames need the result register
   assign q_pop = (state_ff == ST_IDLE) && q_not_empty
                  && ((q_head.op == OP_TICK) || out_free);

   always_comb begin
      state_in      = state_ff;
      ms_count_in   = ms_count_ff;
      last_ms_in    = last_ms_ff;
      armed_in      = armed_ff;
      rpm_in        = rpm_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      divisor_in    = divisor_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      cnt_in        = cnt_ff;
      hold_pos_in   = hold_pos_ff;
      hold_angle_in = hold_angle_ff;

      case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               if (q_head.op == OP_TICK) begin
                  ms_count_in = ms_count_ff + 1'b1;
               end else begin
                  if (capture) begin
                     armed_in   = 1'b0;
                     last_ms_in = ms_count_ff;
                  end
                  if (!q_head.bad && ({1'b0, q_head.pos} < cfg.arm_threshold)) begin
                     armed_in = 1'b1;
                  end
                  if (capture && (elapsed != '0)) begin
                     state_in      = ST_DIVIDE;
                     divisor_in    = elapsed;
                     rem_in        = '0;
                     quo_in        = DIVIDEND;
                     cnt_in        = '0;
                     hold_pos_in   = q_head.pos;
                     hold_angle_in = q_head.angle;
                  end else begin
                     if (capture) begin
                        rpm_in = RPM_MAX;
                     end
                     rsp_valid_in   = 1'b1;
                     rsp_in.pos     = q_head.pos;
                     rsp_in.bad     = q_head.bad;
                     rsp_in.angle   = q_head.angle;
                     rsp_in.rpm     = capture ? RPM_MAX : rpm_ff;
                     rsp_in.updated = capture;
                  end
               end
            end
         end
         ST_DIVIDE: begin
            rem_in = trial_ok ? trial_diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
            quo_in = {quo_ff[DW-2:0], trial_ok};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(DW-1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rpm_in         = quo_sat;
               rsp_valid_in   = 1'b1;
               rsp_in.pos     = hold_pos_ff;
               rsp_in.bad     = 1'b0;
               rsp_in.angle   = hold_angle_ff;
               rsp_in.rpm     = quo_sat;
               rsp_in.updated = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ms_count_ff  <= '0;
         last_ms_ff   <= '0;
         armed_ff     <= 1'b0;
         rpm_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ms_count_ff  <= ms_count_in;
         last_ms_ff   <= last_ms_in;
         armed_ff     <= armed_in;
         rpm_ff       <= rpm_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff        <= rsp_in;
      divisor_ff    <= divisor_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      cnt_ff        <= cnt_in;
      hold_pos_ff   <= hold_pos_in;
      hold_angle_ff <= hold_angle_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

[rtl/efcr_checker.sv]
// Port-level checks on the result channel of encoder_frame_check_rpm.
// Depends on nothing but the top level's ports; bound below.
module efcr_assertions (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> (rsp_tdata[22:0] == 23'd0) && !rsp_tuser[1])
      else $error("bad frame carries position, angle or capture");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[22:14] < 9'd360))
      else $error("angle out of range");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind encoder_frame_check_rpm efcr_assertions u_efcr_assertions (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

[tb/sv/efcr_checker.sv]
// Checker for encoder_frame_check_rpm: watches the req, rsp and csr transfers,
// predicts each frame result and compares it field by field.
// Depends on efcr_pkg for the result layout, opcodes and register indexes.
module efcr_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [efcr_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data,
   output int          fails,
   output int          pending
);
   import efcr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC_BITS = 8;

   // register copies
   logic        res_12bit;
   logic [13:0] win_low;
   logic [14:0] win_high;
   logic [14:0] arm_level;

   // speed capture state
   logic [31:0]         tick_count;
   logic [31:0]         capture_tick;
   logic                armed;
   logic [RPM_BITS-1:0] speed_q8;

   result_type expected_frames[$];

   function automatic result_type decode_frame(input logic [15:0] word);
      result_type  r;
      logic [13:0] data;
      logic [31:0] elapsed;
      logic [63:0] quot;
      r = '0;
      data = word[13:0];
      // bit 15 covers the odd data bits, bit 14 the even ones, both inverted
      r.bad = (word[15] != ~^(data & ODD_MASK)) || (word[14] != ~^(data & EVEN_MASK));
      if (!r.bad) begin
         r.pos = res_12bit ? {2'b00, data[13:2]} : data;
         if (armed && r.pos > win_low && r.pos < win_high) begin
            elapsed = tick_count - capture_tick;
            if (elapsed == 0) begin
               speed_q8 = RPM_MAX;
            end else begin
               quot = (64'd60000 << FRAC_BITS) / elapsed;
               speed_q8 = (quot > RPM_MAX) ? RPM_MAX : quot[RPM_BITS-1:0];
            end
            capture_tick = tick_count;
            armed = 1'b0;
            r.updated = 1'b1;
         end
         // capture runs first, so a position meeting both re-arms
         if (r.pos < arm_level) armed = 1'b1;
         r.angle = 9'((32'(r.pos) * 360) / 16384);
      end
      r.rpm = speed_q8;
      return r;
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fails++;
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         fails = 0;
         res_12bit = 1'b0;
         win_low = WIN_LOW_RESET;
         win_high = WIN_HIGH_RESET;
         arm_level = ARM_RESET;
         tick_count = '0;
         capture_tick = '0;
         armed = 1'b0;
         speed_q8 = '0;
         expected_frames.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_RESOLUTION: res_12bit = csr_data[0];
               CSR_WIN_LOW:    win_low = csr_data[13:0];
               CSR_WIN_HIGH:   win_high = csr_data[14:0];
               CSR_ARM:        arm_level = csr_data[14:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == OP_TICK) tick_count = tick_count + 1;
            else expected_frames.push_back(decode_frame(req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_frames.size() == 0) begin
               $error("result transfer with no frame outstanding");
               fails++;
            end else begin
               want = expected_frames.pop_front();
               check_field("position", want.pos, rsp_tdata[13:0]);
               check_field("position_bad", want.bad, rsp_tuser[0]);
               check_field("angle_deg", want.angle, rsp_tdata[22:14]);
               check_field("rpm_q8", want.rpm, rsp_tdata[46:23]);
               check_field("rpm_updated", want.updated, rsp_tuser[1]);
            end
         end
      end
      pending <= expected_frames.size();
   end

endmodule

[tb/sv/tb_top.sv]
// Top of the encoder_frame_check_rpm testbench: clock, reset, frame and tick
// stimulus, register writes, response back-pressure and the verdict.
// Depends on efcr_pkg, encoder_frame_check_rpm and efcr_checker.
module tb_top;
   import efcr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_CYCLES = 400;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        req_tuser = OP_TICK;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_RESOLUTION;
   logic [15:0] csr_data = '0;

   int fails;
   int pending;
   int items_sent = 0;
   int quiet_cycles = 0;

   logic req_burst = 1'b0;
   logic rsp_burst = 1'b0;
   logic flood = 1'b0;
   logic hold_rsp = 1'b0;

   // shadow of the programmed registers, used to aim positions
   logic cfg_res = 1'b0;
   int   cfg_lo = 14000;
   int   cfg_hi = 16000;
   int   cfg_arm = 1000;

   always #5 clock = ~clock;

   encoder_frame_check_rpm u_dut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   efcr_checker u_checker (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .fails, .pending
   );

   function automatic logic [15:0] framed(input logic [13:0] d);
      return {~^(d & ODD_MASK), ~^(d & EVEN_MASK), d};
   endfunction

   function automatic int pos_limit();
      return cfg_res ? 4095 : 16383;
   endfunction

   function automatic int capture_pos();
      int lo;
      int hi;
      lo = cfg_lo + 1;
      hi = (cfg_hi - 1 < pos_limit()) ? cfg_hi - 1 : pos_limit();
      if (lo <= hi) return $urandom_range(hi, lo);
      return $urandom_range(pos_limit(), 0);
   endfunction

   function automatic int arm_pos();
      int hi;
      if (cfg_arm == 0) return $urandom_range(pos_limit(), 0);
      hi = (cfg_arm - 1 < pos_limit()) ? cfg_arm - 1 : pos_limit();
      return $urandom_range(hi, 0);
   endfunction

   task automatic send_item(input logic op, input logic [15:0] word);
      int gap;
      if ($urandom_range(0, 24) == 0) req_burst = !req_burst;
      gap = (req_burst || flood) ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= word;
      req_tuser <= op;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // good frame that decodes to position p under the current resolution
   task automatic send_frame(input int p);
      logic [13:0] raw;
      raw = cfg_res ? {p[11:0], 2'($urandom)} : 14'(p);
      send_item(OP_FRAME, framed(raw));
   endtask

   task automatic write_reg(input logic [1:0] idx, input int value, input int width);
      csr_valid <= 1'b1;
      csr_index <= idx;
      // junk above the register width must be dropped
      csr_data <= 16'(value) | (16'($urandom) << width);
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_config(input logic res, input int lo, input int hi, input int arm);
      write_reg(CSR_RESOLUTION, res, 1);
      write_reg(CSR_WIN_LOW, lo, 14);
      write_reg(CSR_WIN_HIGH, hi, 15);
      write_reg(CSR_ARM, arm, 15);
      csr_valid <= 1'b0;
      cfg_res = res;
      cfg_lo = lo;
      cfg_hi = hi;
      cfg_arm = arm;
   endtask

   // drain all results, then give trailing ticks time to leave the pipe
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (40) @(posedge clock);
   endtask

   task automatic random_part(input int count);
      int stop;
      int r;
      int k;
      stop = items_sent + count;
      while (items_sent < stop) begin
         r = $urandom_range(0, 99);
         if (r < 65) begin
            // arm, let time pass, then land in the capture window
            send_frame(arm_pos());
            k = ($urandom_range(0, 19) == 0) ? $urandom_range(21, 80) : $urandom_range(0, 12);
            repeat (k) begin
               if ($urandom_range(0, 9) == 0) send_item(OP_FRAME, 16'($urandom));
               send_item(OP_TICK, 16'($urandom));
            end
            send_frame(capture_pos());
         end else if (r < 80) begin
            send_item(OP_FRAME, framed(14'($urandom)) ^ (16'd1 << $urandom_range(0, 15)));
         end else if (r < 88) begin
            send_item(OP_FRAME, 16'($urandom));
         end else if (r < 95) begin
            send_frame($urandom_range(pos_limit(), 0));
         end else begin
            repeat ($urandom_range(1, 4)) send_item(OP_TICK, 16'($urandom));
         end
      end
   endtask

   // response side back-pressure
   initial begin
      int w;
      wait (!reset);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end
         if ($urandom_range(0, 19) == 0) rsp_burst = !rsp_burst;
         w = rsp_burst ? 0 : $urandom_range(0, 11);
         if (w != 0) begin
            rsp_tready <= 1'b0;
            repeat (w) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready) && !hold_rsp);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      do @(posedge clock); while (quiet_cycles < STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset settings: 14-bit, window 14000..16000, arm below 1000
      send_item(OP_FRAME, 16'h0000);              // all zero fails parity
      send_item(OP_FRAME, 16'hFFFF);              // all ones fails parity
      send_frame(0);                              // arms
      send_frame(15000);                          // capture with no elapsed time
      send_frame(16383);
      send_frame(14000);                          // window edges are exclusive
      send_frame(999);
      send_frame(1000);
      repeat (3) send_item(OP_TICK, 16'($urandom));
      send_frame(16000);
      send_frame(14001);                          // capture after three ticks
      send_item(OP_FRAME, framed(14'h1234) ^ 16'h4000);
      send_item(OP_FRAME, framed(14'h2BCD) ^ 16'h8000);
      send_item(OP_TICK, 16'hFFFF);
      send_frame(15500);                          // in window but disarmed
      random_part(100);

      // 12-bit mode, window and arm level wide open: capture then re-arm
      settle();
      set_config(1'b1, 0, 16384, 16384);
      send_frame(100);
      send_item(OP_TICK, 16'h0000);
      send_frame(200);
      send_frame(300);
      send_item(OP_FRAME, framed(14'h3FFF));
      random_part(80);

      // empty window, nothing arms
      settle();
      set_config(1'b0, 16383, 0, 0);
      random_part(60);

      settle();
      begin
         int lo;
         lo = $urandom_range(0, 16383);
         set_config(1'b0, lo, (lo + 4000 > 16384) ? 16384 : lo + $urandom_range(2, 4000),
                    $urandom_range(0, 16384));
      end
      random_part(100);

      settle();
      set_config(1'b1, 3000, 4000, 500);
      random_part(100);

      // back to reset values, with the response side held off while frames pile up
      settle();
      set_config(1'b0, 14000, 16000, 1000);
      hold_rsp = 1'b1;
      flood = 1'b1;
      random_part(30);
      flood = 1'b0;
      random_part(80);

      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (60) @(posedge clock);
      if (fails == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
